// ===== rtl/core/twsa_pkg.sv =====
// Shared types and constants for the time-window spectrum accumulator.
// Used by twsa_bin_mem, twsa_update and time_window_spectrum_accumulator.
// No dependencies.
package twsa_pkg;

  // Number of time windows (bin pairs) held by the block
  localparam int unsigned NUM_WINDOWS = 64;
  localparam int unsigned ADDR_W      = (NUM_WINDOWS > 1) ? $clog2(NUM_WINDOWS) : 1;

  // Fixed field widths
  localparam int unsigned IDX_W = 6;
  localparam int unsigned CNT_W = 16;
  localparam int unsigned BIN_W = 32;

  // Totals clip to this value on readout
  localparam logic [CNT_W-1:0] SAT_MAX = 16'hFFFF;

  typedef logic [ADDR_W-1:0] addr_t;

  typedef enum logic {
    MODE_ACCUM = 1'b0,
    MODE_READ  = 1'b1
  } mode_e;

  // One near/far bin pair as stored in the bin memory
  typedef struct packed {
    logic [BIN_W-1:0] near;
    logic [BIN_W-1:0] far;
  } bin_pair_t;

  // Transaction held in the update stage
  typedef struct packed {
    mode_e            mode;
    logic             in_range;
    logic             first_win;
    addr_t            addr;
    logic [CNT_W-1:0] near_snap;
    logic [CNT_W-1:0] far_snap;
  } item_t;

endpackage

// ===== rtl/core/twsa_bin_mem.sv =====
// Bin memory: NUM_WINDOWS near/far bin pairs, one read and one write port.
// Per-entry valid flags make unwritten entries read as zero after reset.
// Depends on twsa_pkg.
module twsa_bin_mem (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                rd_en_i,
  input  twsa_pkg::addr_t     rd_addr_i,
  output twsa_pkg::bin_pair_t rd_data_o,
  input  logic                wr_en_i,
  input  twsa_pkg::addr_t     wr_addr_i,
  input  twsa_pkg::bin_pair_t wr_data_i
);

  twsa_pkg::bin_pair_t                      mem_q [twsa_pkg::NUM_WINDOWS];
  logic [twsa_pkg::NUM_WINDOWS-1:0]         vld_q;
  twsa_pkg::bin_pair_t                      rd_q;
  logic                                     rd_vld_q;

  // Storage array and registered read
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_q <= mem_q[rd_addr_i];
    end
  end

  // Written flags, cleared at reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        vld_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_vld_q <= vld_q[rd_addr_i];
      end
    end
  end

  // Never-written entries read as zero
  assign rd_data_o = rd_vld_q ? rd_q : '0;

endmodule

// ===== rtl/core/twsa_update.sv =====
// Update datapath: new bin values and saturated totals for one transaction.
// Purely combinational; depends on twsa_pkg.
module twsa_update (
  input  twsa_pkg::item_t                 item_i,
  input  twsa_pkg::bin_pair_t             old_bins_i,
  input  logic [twsa_pkg::CNT_W-1:0]      last_near_i,
  input  logic [twsa_pkg::CNT_W-1:0]      last_far_i,
  output twsa_pkg::bin_pair_t             new_bins_o,
  output logic [twsa_pkg::CNT_W-1:0]      near_total_o,
  output logic [twsa_pkg::CNT_W-1:0]      far_total_o
);

  logic [twsa_pkg::CNT_W-1:0] near_delta;
  logic [twsa_pkg::CNT_W-1:0] far_delta;

  // Window 0 takes the raw snapshot, later windows the wrapped difference
  always_comb begin
    if (item_i.first_win) begin
      near_delta = item_i.near_snap;
      far_delta  = item_i.far_snap;
    end else begin
      near_delta = item_i.near_snap - last_near_i;
      far_delta  = item_i.far_snap - last_far_i;
    end
  end

  // Accumulate or clear
  always_comb begin
    if (item_i.mode == twsa_pkg::MODE_READ) begin
      new_bins_o = '0;
    end else begin
      new_bins_o.near = old_bins_i.near + twsa_pkg::BIN_W'(near_delta);
      new_bins_o.far  = old_bins_i.far + twsa_pkg::BIN_W'(far_delta);
    end
  end

  // Saturated readout; out-of-range windows read as zero
  always_comb begin
    if (!item_i.in_range) begin
      near_total_o = '0;
      far_total_o  = '0;
    end else begin
      near_total_o = (old_bins_i.near >= twsa_pkg::BIN_W'(twsa_pkg::SAT_MAX)) ?
                     twsa_pkg::SAT_MAX : old_bins_i.near[twsa_pkg::CNT_W-1:0];
      far_total_o  = (old_bins_i.far >= twsa_pkg::BIN_W'(twsa_pkg::SAT_MAX)) ?
                     twsa_pkg::SAT_MAX : old_bins_i.far[twsa_pkg::CNT_W-1:0];
    end
  end

endmodule

// ===== rtl/core/time_window_spectrum_accumulator.sv =====
// Two-channel time-window spectrum accumulator, top level.
// Throughput: one transaction per cycle unless stalled; the bin memory is read at acceptance
// and written back when the update stage retires, with a forwarding register for back-to-back hits.
// A read result is loaded into the output register when the update stage retires it;
// a held result stalls a read waiting behind it, and that stalls the input. Reset clears
// control state and all per-window valid flags, so every bin reads as zero after reset.
module time_window_spectrum_accumulator (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          mode_i,
  input  logic [twsa_pkg::IDX_W-1:0]    bin_index_i,
  input  logic [twsa_pkg::CNT_W-1:0]    near_count_i,
  input  logic [twsa_pkg::CNT_W-1:0]    far_count_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [twsa_pkg::CNT_W-1:0]    near_total_o,
  output logic [twsa_pkg::CNT_W-1:0]    far_total_o
);

  logic                       in_acc;
  twsa_pkg::item_t            in_item;
  logic                       s1_vld_q;
  twsa_pkg::item_t            s1_item_q;
  logic                       s1_res;
  logic                       s1_adv;
  logic                       s1_wr;
  logic                       fwd_q;
  twsa_pkg::bin_pair_t        fwd_data_q;
  twsa_pkg::bin_pair_t        mem_rd;
  twsa_pkg::bin_pair_t        old_bins;
  twsa_pkg::bin_pair_t        new_bins;
  logic [twsa_pkg::CNT_W-1:0] last_near_q;
  logic [twsa_pkg::CNT_W-1:0] last_far_q;
  logic [twsa_pkg::CNT_W-1:0] near_total;
  logic [twsa_pkg::CNT_W-1:0] far_total;
  logic                       out_vld_q;
  logic [twsa_pkg::CNT_W-1:0] near_total_q;
  logic [twsa_pkg::CNT_W-1:0] far_total_q;

  // Decode the incoming transaction
  always_comb begin
    in_item.mode      = twsa_pkg::mode_e'(mode_i);
    in_item.in_range  = (32'(bin_index_i) < twsa_pkg::NUM_WINDOWS);
    in_item.first_win = (bin_index_i == '0);
    in_item.addr      = twsa_pkg::addr_t'(bin_index_i);
    in_item.near_snap = near_count_i;
    in_item.far_snap  = far_count_i;
  end

  // Stage handshake: accumulates always retire, reads need room at the output
  assign s1_res     = (s1_item_q.mode == twsa_pkg::MODE_READ);
  assign s1_adv     = s1_vld_q && (!s1_res || !out_vld_q || !out_stall_i);
  assign s1_wr      = s1_adv && s1_item_q.in_range;
  assign in_stall_o = s1_vld_q && !s1_adv;
  assign in_acc     = in_valid_i && !in_stall_o;

  twsa_bin_mem u_bin_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (in_acc),
    .rd_addr_i (in_item.addr),
    .rd_data_o (mem_rd),
    .wr_en_i   (s1_wr),
    .wr_addr_i (s1_item_q.addr),
    .wr_data_i (new_bins)
  );

  // Previous write to the same bin lands on the same edge as our read
  assign old_bins = fwd_q ? fwd_data_q : mem_rd;

  twsa_update u_update (
    .item_i       (s1_item_q),
    .old_bins_i   (old_bins),
    .last_near_i  (last_near_q),
    .last_far_i   (last_far_q),
    .new_bins_o   (new_bins),
    .near_total_o (near_total),
    .far_total_o  (far_total)
  );

  // Update stage payload and forwarding data
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_item_q  <= in_item;
      fwd_data_q <= new_bins;
    end
  end

  // Update stage control, snapshot memory
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q    <= 1'b0;
      fwd_q       <= 1'b0;
      last_near_q <= '0;
      last_far_q  <= '0;
    end else begin
      if (in_acc) begin
        s1_vld_q <= 1'b1;
        fwd_q    <= s1_wr && (s1_item_q.addr == in_item.addr);
      end else if (s1_adv) begin
        s1_vld_q <= 1'b0;
      end
      if (s1_wr && !s1_res) begin
        last_near_q <= s1_item_q.near_snap;
        last_far_q  <= s1_item_q.far_snap;
      end
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (s1_adv && s1_res) begin
      out_vld_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && s1_res) begin
      near_total_q <= near_total;
      far_total_q  <= far_total;
    end
  end

  assign out_valid_o  = out_vld_q;
  assign near_total_o = near_total_q;
  assign far_total_o  = far_total_q;

endmodule
